>>> rtl/bpdc_pkg.sv
// shared types and constants for the backlight pulse dimming controller
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package bpdc_pkg;

   // default number of brightness steps
   localparam int STEPS_DEFAULT = 16;

   // field widths on the stream buses
   localparam int LEVEL_W     = 8;
   localparam int STEP_OUT_W  = 4;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   // mapping constants: target = (level * (STEPS - 1) + ROUND_ADD) / FULL_LEVEL
   localparam int ROUND_ADD   = 127;
   localparam int FULL_LEVEL  = 255;

   // pin action codes
   typedef logic [1:0] action_type;
   localparam action_type ACT_OFF      = 2'd0;
   localparam action_type ACT_ENABLE   = 2'd1;
   localparam action_type ACT_PULSE    = 2'd2;
   localparam action_type ACT_NOCHANGE = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       load;    // capture the request level
      logic       sum;     // form level * (STEPS - 1) + rounding
      logic       div;     // divide the sum by the full level
      logic       plan;    // work out the pulse count, commit the step
      logic       emit;    // load the result register
      logic       dec;     // count one pulse off
      logic       last;    // last flag of the emitted result
      action_type action;  // action code of the emitted result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic target_zero;  // target step is 0
      logic cur_zero;     // backlight was off before this request
      logic pulses_zero;  // no dimming pulse left
      logic count_one;    // exactly one dimming pulse left
      logic out_free;     // result register can take a new result
   } status_type;

endpackage

>>> rtl/backlight_pulse_dimming_controller_core.sv
// top level of the backlight pulse dimming controller
// depends on bpdc_pkg, bpdc_controller and bpdc_datapath
//
//   channel   direction  data                                  tlast
//   req_      in         tdata[7:0] level                      -
//   rsp_      out        tdata[1:0] action, tdata[5:2] step    last pin action
//
// a request is loaded, summed, divided and planned; the first-action state emits nothing when
// the request opens with a dimming pulse; a request gives 1 to STEPS pin actions in all
// the pulse counter sets the length of a request
// the next request is taken as soon as the final action sits in the result register
// a stalled rsp_ side holds the sequencer in place, no action is lost
// synchronous active-high reset: backlight taken as off (step 0), no result pending
`timescale 1ns / 1ps

module backlight_pulse_dimming_controller_core
   import bpdc_pkg::*;
#(
   parameter int STEPS = STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] level
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [1:0] action, [5:2] step, [7:6] zero
   output logic                  rsp_tlast
);

   cmd_type               cmd;
   status_type            status;
   action_type            rsp_action;
   logic [STEP_OUT_W-1:0] rsp_step;

   bpdc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bpdc_datapath #(
      .STEPS (STEPS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .level      (req_tdata[LEVEL_W-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_action (rsp_action),
      .rsp_step   (rsp_step),
      .rsp_last   (rsp_tlast)
   );

   // pack the result fields
   assign rsp_tdata = {(RSP_DATA_W - STEP_OUT_W - 2)'(0), rsp_step, rsp_action};

   // a taken request blocks the next one while it is mapped
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous one is mapped");

   // an off action always closes its request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ACT_OFF) |-> rsp_tlast)
      else $error("off action without last");

   // a no-change action always closes its request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ACT_NOCHANGE) |-> rsp_tlast)
      else $error("no-change action without last");

   // turning on is always followed by at least one dimming pulse
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ACT_ENABLE) |-> !rsp_tlast)
      else $error("enable action marked last");

endmodule

>>> rtl/bpdc_datapath.sv
// datapath: step mapping, current step, pulse counter and result register
// depends on bpdc_pkg; driven by bpdc_controller
`timescale 1ns / 1ps

module bpdc_datapath
   import bpdc_pkg::*;
#(
   parameter int STEPS = STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [LEVEL_W-1:0]    level,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output action_type            rsp_action,
   output logic [STEP_OUT_W-1:0] rsp_step,
   output logic                  rsp_last
);

   // step values 0..STEPS-1 and the widest mapping sum
   localparam int SW = $clog2(STEPS);
   localparam int XW = $clog2(FULL_LEVEL * (STEPS - 1) + ROUND_ADD + 1);
   localparam logic [SW:0] STEPS_W = (SW + 1)'(STEPS);

   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [XW-1:0]         sum_ff, sum_in;
   logic [SW-1:0]         target_ff, target_in;
   logic [SW-1:0]         cur_ff, cur_in;
   logic [SW-1:0]         count_ff, count_in;
   logic                  target_zero_ff, target_zero_in;
   logic                  cur_zero_ff, cur_zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   action_type            rsp_action_ff, rsp_action_in;
   logic [STEP_OUT_W-1:0] rsp_step_ff, rsp_step_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [XW:0]           div_sum;
   logic [SW:0]           pulses;
   logic                  out_free;

   // divide by 255: (x + (x >> 8) + 1) >> 8, exact for x below 65535
   assign div_sum = {1'b0, sum_ff} + (XW + 1)'(sum_ff >> 8) + (XW + 1)'(1);

   // pulse count modulo STEPS from the current and target steps
   always_comb begin
      if (cur_ff == '0) begin
         pulses = STEPS_W - {1'b0, target_ff};
      end else if (cur_ff >= target_ff) begin
         pulses = {1'b0, cur_ff} - {1'b0, target_ff};
      end else begin
         pulses = STEPS_W + {1'b0, cur_ff} - {1'b0, target_ff};
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next values
   always_comb begin
      level_in       = level_ff;
      sum_in         = sum_ff;
      target_in      = target_ff;
      cur_in         = cur_ff;
      count_in       = count_ff;
      target_zero_in = target_zero_ff;
      cur_zero_in    = cur_zero_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_step_in    = rsp_step_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.load) begin
         level_in = level;
      end
      if (cmd.sum) begin
         sum_in = XW'(level_ff) * XW'(STEPS - 1) + XW'(ROUND_ADD);
      end
      if (cmd.div) begin
         target_in = SW'(div_sum >> 8);
      end
      // the step is committed here, the flags keep what the emit stage needs
      if (cmd.plan) begin
         count_in       = SW'(pulses);
         target_zero_in = (target_ff == '0);
         cur_zero_in    = (cur_ff == '0);
         cur_in         = target_ff;
      end
      if (cmd.dec) begin
         count_in = count_ff - SW'(1);
      end

      // result register
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = cmd.action;
         rsp_step_in   = STEP_OUT_W'(target_ff);
         rsp_last_in   = cmd.last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      level_ff       <= level_in;
      sum_ff         <= sum_in;
      target_ff      <= target_in;
      count_ff       <= count_in;
      target_zero_ff <= target_zero_in;
      cur_zero_ff    <= cur_zero_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_step_ff    <= rsp_step_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign status.target_zero = target_zero_ff;
   assign status.cur_zero    = cur_zero_ff;
   assign status.pulses_zero = (count_ff == '0);
   assign status.count_one   = (count_ff == SW'(1));
   assign status.out_free    = out_free;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_step   = rsp_step_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> rtl/bpdc_controller.sv
// controller: sequences mapping, planning and emission of pin actions
// depends on bpdc_pkg; drives bpdc_datapath
`timescale 1ns / 1ps

module bpdc_controller
   import bpdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUM   = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_PLAN  = 3'd3;
   localparam logic [2:0] S_FIRST = 3'd4;
   localparam logic [2:0] S_PULSE = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            cmd.plan = 1'b1;
            state_in = S_FIRST;
         end
         // first action: off, enable, no change, or straight to pulses
         S_FIRST: begin
            if (status.target_zero) begin
               if (status.out_free) begin
                  cmd.emit   = 1'b1;
                  cmd.action = ACT_OFF;
                  cmd.last   = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (status.cur_zero) begin
               if (status.out_free) begin
                  cmd.emit   = 1'b1;
                  cmd.action = ACT_ENABLE;
                  cmd.last   = status.pulses_zero;
                  state_in   = status.pulses_zero ? S_IDLE : S_PULSE;
               end
            end else if (status.pulses_zero) begin
               if (status.out_free) begin
                  cmd.emit   = 1'b1;
                  cmd.action = ACT_NOCHANGE;
                  cmd.last   = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               state_in = S_PULSE;
            end
         end
         // one dimming pulse per free result slot
         S_PULSE: begin
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.dec    = 1'b1;
               cmd.action = ACT_PULSE;
               cmd.last   = status.count_one;
               if (status.count_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> tb/testbench.sv
// self-checking testbench for backlight_pulse_dimming_controller_core
// depends on bpdc_pkg and the core; predicts every pin action of each brightness request
// directed and random requests, at first with random idle bursts on both stream sides
`timescale 1ns / 1ps

module testbench;
   import bpdc_pkg::*;

   localparam int STEPS = STEPS_DEFAULT;
   localparam int SETTLE_CYCLES = STEPS + 12;

   // one expected pin action
   typedef struct {
      action_type      action;
      logic [3:0]      step;
      logic            last;
   } pin_action_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] level
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [1:0] action, [5:2] step, [7:6] zero
   logic                  rsp_tlast;

   // predicted pin actions, oldest first
   pin_action_type pin_action_q[$];
   // step the backlight sits on in the prediction
   int unsigned    model_step;

   int  error_count;
   int  request_count;
   int  action_count[4];
   bit  sender_idle_on;
   bit  receiver_idle_on;
   int  stall_left;
   logic [7:0] prev_level;

   backlight_pulse_dimming_controller_core #(
      .STEPS(STEPS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, 4 ns period
   always #2 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("timeout at %0t ns, %0d pin actions still pending", $time, pin_action_q.size());
      $display("** backlight_pulse_dimming_controller_core: FAILED **");
      $finish;
   end

   // push one pin action onto the prediction queue
   function automatic void push_action(action_type action, int unsigned target, bit last);
      pin_action_type a;
      a.action = action;
      a.step   = target[3:0];
      a.last   = last;
      pin_action_q.push_back(a);
   endfunction

   // map a level to its target step and predict the pin action sequence
   function automatic void plan_pin_actions(logic [7:0] level);
      int unsigned target;
      int unsigned cur;
      int unsigned pulses;
      int unsigned n;
      target = (int'(level) * (STEPS - 1) + ROUND_ADD) / FULL_LEVEL;
      cur    = model_step % STEPS;
      pulses = 0;
      n      = 0;
      if (target == 0) begin
         push_action(ACT_OFF, target, 1'b1);
         n = 1;
      end else begin
         // backlight off: raise the line, then count down from the top
         if (cur == 0) begin
            cur = STEPS;
         end
         pulses = (STEPS + cur - target) % STEPS;
         if (cur == STEPS) begin
            push_action(ACT_ENABLE, target, pulses == 0);
            n = 1;
         end
         for (int unsigned i = 0; i < pulses; i++) begin
            push_action(ACT_PULSE, target, i == pulses - 1);
            n++;
         end
         if (n == 0) begin
            push_action(ACT_NOCHANGE, target, 1'b1);
         end
      end
      model_step = target;
   endfunction

   // result checker: compare each accepted pin action with the oldest prediction
   always @(posedge clock) begin
      pin_action_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pin_action_q.size() == 0) begin
            $display("%0t ns: unexpected pin action, got action=%0d step=%0d last=%0d",
                     $time, rsp_tdata[1:0], rsp_tdata[5:2], rsp_tlast);
            error_count++;
         end else begin
            want = pin_action_q.pop_front();
            action_count[want.action]++;
            if (rsp_tdata[1:0] !== want.action) begin
               $display("%0t ns: action mismatch, expected %0d, actual %0d",
                        $time, want.action, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[5:2] !== want.step) begin
               $display("%0t ns: step mismatch, expected %0d, actual %0d",
                        $time, want.step, rsp_tdata[5:2]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t ns: last mismatch, expected %0d, actual %0d",
                        $time, want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[7:6] !== 2'b00) begin
               $display("%0t ns: pad bits mismatch, expected 0, actual %0d",
                        $time, rsp_tdata[7:6]);
               error_count++;
            end
         end
      end
   end

   // result side backpressure in random bursts
   always @(posedge clock) begin
      if (reset || !receiver_idle_on) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // send one brightness request, with an optional idle burst before it
   task automatic send_level(input logic [7:0] level);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= level;
      do @(posedge clock); while (!req_tready);
      plan_pin_actions(level);
      request_count++;
      prev_level = level;
   endtask

   // hold off the sender until every predicted pin action has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pin_action_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // off request straight after reset, turn on to full, same level again
   task automatic test_off_and_full();
      send_level(8'h00);
      send_level(8'hFF);
      send_level(8'hFF);
   endtask

   // mapping boundaries and long pulse trains, including the 16-action turn on
   task automatic test_step_boundaries();
      logic [7:0] levels[] = '{8'd9, 8'd255, 8'd0, 8'd9, 8'd8, 8'd247, 8'd246,
                               8'd128, 8'd136, 8'd137, 8'd170, 8'd85, 8'hAA,
                               8'h55, 8'd1, 8'd254, 8'd0, 8'd0};
      foreach (levels[i]) begin
         send_level(levels[i]);
      end
   endtask

   // random levels: mostly fresh steps, some off requests, repeats and extremes
   task automatic test_random_levels(input int count);
      logic [7:0] level;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0:       level = 8'($urandom_range(0, 8));
            1:       level = prev_level;
            2:       level = 8'($urandom_range(247, 255));
            default: level = 8'($urandom_range(0, 255));
         endcase
         send_level(level);
      end
   endtask

   initial begin
      error_count    = 0;
      request_count  = 0;
      model_step     = 0;
      prev_level     = 8'h00;
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      foreach (action_count[i]) action_count[i] = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_off_and_full();
      test_step_boundaries();
      wait_drained();

      test_random_levels(100);
      wait_drained();

      // stretch with no idling on the result side only
      receiver_idle_on = 1'b0;
      test_random_levels(60);

      // tail of the run: no idling anywhere
      sender_idle_on = 1'b0;
      test_random_levels(100);
      wait_drained();

      $display("%0d brightness requests; pin actions off=%0d enable=%0d pulse=%0d none=%0d",
               request_count, action_count[ACT_OFF], action_count[ACT_ENABLE],
               action_count[ACT_PULSE], action_count[ACT_NOCHANGE]);
      $display("%0d mismatches, %0d pin actions never seen", error_count, pin_action_q.size());
      if (error_count == 0 && pin_action_q.size() == 0) begin
         $display("** backlight_pulse_dimming_controller_core: PASSED **");
      end else begin
         $display("** backlight_pulse_dimming_controller_core: FAILED **");
      end
      $finish;
   end

endmodule
